@@ design/wmsm_pkg.sv @@
// Shared types and constants for the windowed mean unit.
// Used by the front, back and top level; no dependencies of its own.
package wmsm_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam int SAMPLE_WIDTH = 32;
	localparam int MEAN_WIDTH   = 32;
	localparam int LEN_WIDTH    = 7;
	localparam int OFF_WIDTH    = 6;
	localparam int ADDR_WIDTH   = 3;
	localparam int DATA_WIDTH   = 32;

	localparam logic [LEN_WIDTH-1:0] LEN_RESET = 7'd3;
	localparam logic [OFF_WIDTH-1:0] OFF_RESET = 6'd0;

	// Register select, taken from address bit 2.
	localparam logic REG_WINDOW_LEN    = 1'b0;
	localparam logic REG_WINDOW_OFFSET = 1'b1;

	typedef struct packed {
		logic [LEN_WIDTH-1:0] len;
		logic [OFF_WIDTH-1:0] off;
		logic                 clear;
	} wmsm_cfg_t;

	typedef struct packed {
		logic run_last;
		logic series_done;
	} wmsm_flags_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_GEN,
		F_PUSH
	} wmsm_front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} wmsm_back_state_t;

endpackage

@@ design/wmsm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wmsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/wmsm_front.sv @@
// Front end: accepts samples, keeps running prefix sums in a ring RAM and
// emits one (sum, count) transaction per owed window into the queue.
// Depends on wmsm_pkg and wmsm_ram.
module wmsm_front import wmsm_pkg::*; #(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int SUM_BITS    = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF + 1),
	parameter int CNT_BITS    = $clog2(MAX_WINDOW_DEF + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wmsm_cfg_t                      cfg,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           sample_present,
	input  logic                           series_end,
	output logic                           q_push,
	output logic [SUM_BITS-1:0]            q_sum,
	output logic [CNT_BITS-1:0]            q_cnt,
	output wmsm_flags_t                    q_flags,
	input  logic                           q_full
);

	localparam int NB  = $clog2(MAX_WINDOW + 2);
	localparam int LB  = (NB > LEN_WIDTH) ? NB : LEN_WIDTH;
	localparam int RD  = MAX_WINDOW + 1;
	localparam int AB  = $clog2(RD);
	localparam int EXT = (SAMPLE_BITS > SAMPLE_WIDTH) ? SAMPLE_BITS : SAMPLE_WIDTH;
	localparam int RW  = SUM_BITS + CNT_BITS;

	wmsm_front_state_t state_q, state_d;

	logic [SUM_BITS-1:0] p_q;
	logic [CNT_BITS-1:0] c_q;
	logic [NB-1:0]       n_q;
	logic [AB-1:0]       wp_q;
	logic [NB-1:0]       m_q;
	logic [NB-1:0]       mlow_q;
	logic                last_q;
	logic                use_base_q;

	logic [LB-1:0]       len_x, off_x, w_x, o_x;
	logic [NB-1:0]       w_eff, o_eff, mtop, d;
	logic [EXT-1:0]      raw;
	logic [SUM_BITS-1:0] x_ext, p_new, base_sum;
	logic [CNT_BITS-1:0] c_new, base_cnt;
	logic [AB:0]         rd_t;
	logic [AB-1:0]       raddr;
	logic                accept, skip, use_base, final_m, step, finish;
	logic                ram_we, ram_re;
	logic [RW-1:0]       ram_rdata;

	always_comb begin
		len_x = LB'(cfg.len);
		off_x = LB'(cfg.off);
		if (cfg.len == '0) begin
			w_x = LB'(1);
		end else if (len_x > LB'(MAX_WINDOW)) begin
			w_x = LB'(MAX_WINDOW);
		end else begin
			w_x = len_x;
		end
		if (off_x >= w_x) begin
			o_x = w_x - LB'(1);
		end else begin
			o_x = off_x;
		end
	end

	assign w_eff = NB'(w_x);
	assign o_eff = NB'(o_x);
	assign mtop  = w_eff - o_eff - NB'(1);

	assign raw   = EXT'($unsigned(sample));
	assign x_ext = SUM_BITS'($signed(raw[SAMPLE_BITS-1:0]));
	assign p_new = p_q + (sample_present ? x_ext : '0);
	assign c_new = c_q + CNT_BITS'(sample_present);

	// Window for position m covers the newest d samples; the prefix entry d+1
	// back from the write slot is subtracted when the series is longer than d.
	assign d        = m_q + o_eff + NB'(1);
	assign skip     = (m_q >= n_q);
	assign use_base = (n_q > d);
	assign final_m  = (m_q == mlow_q);
	assign rd_t     = {1'b0, wp_q} + (AB+1)'(RD) - (AB+1)'(d) - (AB+1)'(1);
	assign raddr    = (rd_t >= (AB+1)'(RD)) ? AB'(rd_t - (AB+1)'(RD)) : AB'(rd_t);

	assign base_sum = use_base_q ? ram_rdata[RW-1:CNT_BITS] : '0;
	assign base_cnt = use_base_q ? ram_rdata[CNT_BITS-1:0] : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					state_d = F_GEN;
				end
			end
			F_GEN: begin
				if (!skip) begin
					state_d = F_PUSH;
				end else if (final_m) begin
					state_d = F_IDLE;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = final_m ? F_IDLE : F_GEN;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		accept   = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		q_push   = 1'b0;
		step     = 1'b0;
		finish   = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				ram_we   = in_valid;
			end
			F_GEN: begin
				ram_re = !skip && use_base;
				step   = skip && !final_m;
				finish = skip && final_m;
			end
			F_PUSH: begin
				q_push = !q_full;
				step   = !q_full && !final_m;
				finish = !q_full && final_m;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign q_sum               = p_q - base_sum;
	assign q_cnt               = c_q - base_cnt;
	assign q_flags.run_last    = final_m;
	assign q_flags.series_done = final_m && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q        <= '0;
			c_q        <= '0;
			n_q        <= '0;
			wp_q       <= '0;
			m_q        <= '0;
			mlow_q     <= '0;
			last_q     <= 1'b0;
			use_base_q <= 1'b0;
		end else if (cfg.clear || (finish && last_q)) begin
			p_q  <= '0;
			c_q  <= '0;
			n_q  <= '0;
			wp_q <= '0;
		end else begin
			if (accept) begin
				p_q    <= p_new;
				c_q    <= c_new;
				n_q    <= (n_q == NB'(MAX_WINDOW + 1)) ? n_q : n_q + NB'(1);
				wp_q   <= (wp_q == AB'(RD - 1)) ? '0 : wp_q + AB'(1);
				m_q    <= mtop;
				mlow_q <= series_end ? '0 : mtop;
				last_q <= series_end;
			end
			if (state_q == F_GEN) begin
				use_base_q <= use_base;
			end
			if (step) begin
				m_q <= m_q - NB'(1);
			end
		end
	end

	wmsm_ram #(
		.WIDTH(RW),
		.DEPTH(RD)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata ({p_new, c_new}),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ design/wmsm_queue.sv @@
// Small register FIFO that decouples the front end from the divider.
// No dependencies.
module wmsm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PB = $clog2(DEPTH);
	localparam int CB = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PB-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CB-1:0]    count_q;

	assign full  = (count_q == CB'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(DEPTH - 1)) ? '0 : wr_ptr_q + PB'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(DEPTH - 1)) ? '0 : rd_ptr_q + PB'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CB'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

endmodule

@@ design/wmsm_back.sv @@
// Back end: divides each window sum by its nonzero count one bit per cycle and
// holds the result, or zero for a zero count, in the output register.
// Depends on wmsm_pkg.
module wmsm_back import wmsm_pkg::*; #(
	parameter int SUM_BITS = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF + 1),
	parameter int CNT_BITS = $clog2(MAX_WINDOW_DEF + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  logic [SUM_BITS-1:0]          q_sum,
	input  logic [CNT_BITS-1:0]          q_cnt,
	input  wmsm_flags_t                  q_flags,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [MEAN_WIDTH-1:0] mean,
	output logic                         mean_present,
	output logic                         run_last,
	output logic                         series_done
);

	localparam int SB = $clog2(SUM_BITS);
	localparam int QB = (SUM_BITS > MEAN_WIDTH) ? SUM_BITS : MEAN_WIDTH;

	wmsm_back_state_t state_q, state_d;

	logic [SUM_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0]   rem_q, div_q;
	logic [SB-1:0]         step_q;
	logic                  neg_q, present_q;
	wmsm_flags_t           flags_q;
	logic                  out_valid_q;
	logic [MEAN_WIDTH-1:0] mean_q;
	logic                  mean_present_q;
	wmsm_flags_t           out_flags_q;

	logic [CNT_BITS:0]     trial;
	logic                  fits, div_last, div_en, load;
	logic [SUM_BITS-1:0]   mag, qs;
	logic [QB-1:0]         qx;

	assign mag      = q_sum[SUM_BITS-1] ? (~q_sum + SUM_BITS'(1)) : q_sum;
	assign trial    = {rem_q, quo_q[SUM_BITS-1]};
	assign fits     = (trial >= {1'b0, div_q});
	assign div_last = (step_q == SB'(SUM_BITS - 1));
	assign qs       = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;
	assign qx       = QB'($signed(qs));

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = (q_cnt != '0) ? B_DIV : B_HOLD;
				end
			end
			B_DIV: begin
				if (div_last) begin
					state_d = B_HOLD;
				end
			end
			B_HOLD: begin
				if (!out_valid_q || !out_stall) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		div_en = 1'b0;
		load   = 1'b0;
		case (state_q)
			B_IDLE:  q_pop  = !q_empty;
			B_DIV:   div_en = 1'b1;
			B_HOLD:  load   = !out_valid_q || !out_stall;
			default: q_pop  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Restoring division on the magnitude; the sign is put back at the end,
	// which gives truncation toward zero.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q     <= mag;
			rem_q     <= '0;
			div_q     <= q_cnt;
			step_q    <= '0;
			neg_q     <= q_sum[SUM_BITS-1];
			present_q <= (q_cnt != '0);
			flags_q   <= q_flags;
		end else if (div_en) begin
			quo_q  <= {quo_q[SUM_BITS-2:0], fits};
			rem_q  <= fits ? CNT_BITS'(trial - {1'b0, div_q}) : CNT_BITS'(trial);
			step_q <= step_q + SB'(1);
		end
		if (load) begin
			mean_q         <= present_q ? qx[MEAN_WIDTH-1:0] : '0;
			mean_present_q <= present_q;
			out_flags_q    <= flags_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign mean_present = mean_present_q;
	assign run_last     = out_flags_q.run_last;
	assign series_done  = out_flags_q.series_done;

endmodule

@@ design/windowed_mean_skip_missing_unit.sv @@
// Top level of the windowed mean unit: configuration registers, front end,
// queue and divider back end. Depends on wmsm_pkg, wmsm_front, wmsm_queue, wmsm_back.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  sample, sample_present, series_end
//   output   out        out_valid / out_stall mean, mean_present, run_last, series_done
//   config   in         APB psel / penable   paddr, pwdata, prdata
//
// A sample is taken while the front end is idle; in_stall then stays high through a
// ring RAM lookup state and a queue push state per owed window position, through the
// lookup state alone per position not yet in the series, and while the queue is full.
// A present result passes the back end's pop, divide and hold states; a missing one
// skips the divide state. An end-of-series flush owes up to a window of results.
// Reset needs no clearing pass: the ring is only read at entries of the current series.
module windowed_mean_skip_missing_unit import wmsm_pkg::*; #(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_WIDTH-1:0]          paddr,
	input  logic [DATA_WIDTH-1:0]          pwdata,
	output logic [DATA_WIDTH-1:0]          prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           sample_present,
	input  logic                           series_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [MEAN_WIDTH-1:0]   mean,
	output logic                           mean_present,
	output logic                           run_last,
	output logic                           series_done
);

	localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int QW       = SUM_BITS + CNT_BITS + $bits(wmsm_flags_t);

	logic [LEN_WIDTH-1:0] len_q;
	logic [OFF_WIDTH-1:0] off_q;
	logic                 cfg_wr;
	wmsm_cfg_t            cfg;

	logic                q_push, q_pop, q_full, q_empty;
	logic [SUM_BITS-1:0] f_sum, b_sum;
	logic [CNT_BITS-1:0] f_cnt, b_cnt;
	wmsm_flags_t         f_flags, b_flags;
	logic [QW-1:0]       q_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			off_q <= OFF_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WINDOW_LEN:    len_q <= pwdata[LEN_WIDTH-1:0];
				REG_WINDOW_OFFSET: off_q <= pwdata[OFF_WIDTH-1:0];
				default:           len_q <= len_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW_LEN:    prdata = DATA_WIDTH'(len_q);
			REG_WINDOW_OFFSET: prdata = DATA_WIDTH'(off_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.len   = len_q;
	assign cfg.off   = off_q;
	assign cfg.clear = cfg_wr;

	wmsm_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_BITS    (SUM_BITS),
		.CNT_BITS    (CNT_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.sample_present (sample_present),
		.series_end     (series_end),
		.q_push         (q_push),
		.q_sum          (f_sum),
		.q_cnt          (f_cnt),
		.q_flags        (f_flags),
		.q_full         (q_full)
	);

	wmsm_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_sum, f_cnt, f_flags}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_sum, b_cnt, b_flags} = q_rdata;

	wmsm_back #(
		.SUM_BITS (SUM_BITS),
		.CNT_BITS (CNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_sum        (b_sum),
		.q_cnt        (b_cnt),
		.q_flags      (b_flags),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean         (mean),
		.mean_present (mean_present),
		.run_last     (run_last),
		.series_done  (series_done)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("window transaction pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("window transaction popped from an empty queue");

	a_missing_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mean_present) |-> (mean == '0))
		else $error("missing result carries a nonzero mean");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && series_done) |-> run_last)
		else $error("series end result not marked as last of its input");

endmodule
